[rtl/leading_pattern_stripper_core_macros.svh]
// Assertion helpers for the modules that check their own logic; lps_back includes them.
`ifndef LEADING_PATTERN_STRIPPER_CORE_MACROS_SVH
`define LEADING_PATTERN_STRIPPER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lps_pkg.sv]
package lps_pkg;

    localparam int BYTE_W = 8;
    localparam int PAT_W  = 64;
    localparam int LEN_W  = 4;
    localparam int LIM_W  = 8;
    localparam int CNT_W  = 4;
    localparam int POS_W  = 3;
    localparam int IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_STRIP_PATTERN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_STRIP_LIMIT    = 2'd2;

    // Register values as seen by the datapath.
    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length;
        logic [LIM_W-1:0] limit;
    } lps_cfg_t;

    // One command for the back end: replay held pattern bytes, then an
    // optional pass-through byte, with the token end marked if needed.
    typedef struct packed {
        logic [CNT_W-1:0]  held;
        logic              has_byte;
        logic [BYTE_W-1:0] data;
        logic              last;
    } lps_cmd_t;

endpackage

[rtl/lps_front.sv]
module lps_front #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lps_pkg::lps_cfg_t      cfg,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             token_byte,
    input  logic                   token_last,
    input  logic                   q_full,
    output logic                   q_push,
    output lps_pkg::lps_cmd_t      q_cmd
);
    import lps_pkg::*;

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN_BYTES);

    logic             phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LIM_W-1:0] copies_reg, copies_next;

    logic [LEN_W-1:0]  eff_len;
    logic [BYTE_W-1:0] pat_byte;
    logic [CNT_W-1:0]  pos_inc;
    logic              match;
    logic              accept;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;

    // Clamp the configured length into the supported range.
    always_comb
    begin
        if (cfg.length == '0)
            eff_len = LEN_W'(1);
        else if (cfg.length > MaxLen)
            eff_len = MaxLen;
        else
            eff_len = cfg.length;
    end

    assign pat_byte = cfg.pattern[pos_reg * BYTE_W +: BYTE_W];
    assign pos_inc  = {1'b0, pos_reg} + CNT_W'(1);
    assign match    = phase_reg && (copies_reg < cfg.limit) && (token_byte == pat_byte);

    // Classify the byte and work out the next match state.
    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        copies_next    = copies_reg;
        q_cmd.held     = '0;
        q_cmd.has_byte = 1'b0;
        q_cmd.data     = token_byte;
        q_cmd.last     = token_last;
        if (match)
        begin
            if (pos_inc >= eff_len)
            begin
                copies_next = copies_reg + LIM_W'(1);
                pos_next    = '0;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
            if (token_last)
                q_cmd.held = {1'b0, pos_next};
        end
        else
        begin
            if (phase_reg)
                q_cmd.held = {1'b0, pos_reg};
            q_cmd.has_byte = 1'b1;
            phase_next     = 1'b0;
            pos_next       = '0;
        end
        if (token_last)
        begin
            phase_next  = 1'b1;
            pos_next    = '0;
            copies_next = '0;
        end
    end

    // Bytes that are only absorbed into a partial match produce no command.
    assign q_push = accept && (q_cmd.has_byte || (q_cmd.held != '0) || token_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b1;
            pos_reg    <= '0;
            copies_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            copies_reg <= copies_next;
        end
    end

endmodule

[rtl/lps_queue.sv]
module lps_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lps_pkg::lps_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output lps_pkg::lps_cmd_t head_cmd,
    output logic              empty
);
    import lps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);

    lps_cmd_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;

    assign full     = (count_reg == CNT_QW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Storage for queued commands.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_QW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_QW'(1);
        end
    end

endmodule

[rtl/lps_back.sv]
`include "leading_pattern_stripper_core_macros.svh"

module lps_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lps_pkg::lps_cfg_t cfg,
    input  logic              q_empty,
    input  lps_pkg::lps_cmd_t head_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              token_end,
    output logic              run_last
);
    import lps_pkg::*;

    logic [CNT_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              byte_valid_reg;
    logic              token_end_reg;
    logic              run_last_reg;

    logic              tail;
    logic              in_replay;
    logic              final_res;
    logic              load;
    logic [BYTE_W-1:0] res_byte;
    logic              res_valid;

    // A tail result follows the replay: the pass-through byte or an empty end.
    assign tail      = head_cmd.has_byte || (head_cmd.held == '0);
    assign in_replay = (idx_reg < head_cmd.held);

    // Select the result at the current step of the head command.
    always_comb
    begin
        if (in_replay)
        begin
            res_byte  = cfg.pattern[idx_reg[POS_W-1:0] * BYTE_W +: BYTE_W];
            res_valid = 1'b1;
            final_res = !tail && (idx_reg == head_cmd.held - CNT_W'(1));
        end
        else
        begin
            res_byte  = head_cmd.has_byte ? head_cmd.data : '0;
            res_valid = head_cmd.has_byte;
            final_res = 1'b1;
        end
    end

    assign load  = !q_empty && (!out_valid_reg || !out_stall);
    assign q_pop = load && final_res;

    // Step counter and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= final_res ? '0 : idx_reg + CNT_W'(1);
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= res_byte;
            byte_valid_reg <= res_valid;
            token_end_reg  <= final_res && head_cmd.last;
            run_last_reg   <= final_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign token_end  = token_end_reg;
    assign run_last   = run_last_reg;

    `LPS_ASSERT_SAME(a_idx_in_range, clk, rst_n, !q_empty, idx_reg <= head_cmd.held,
        "replay step beyond held count")
    `LPS_ASSERT_SAME(a_idx_idle, clk, rst_n, q_empty, idx_reg == '0,
        "replay step not cleared with empty queue")
    `LPS_ASSERT_SAME(a_end_is_run_last, clk, rst_n, out_valid_reg && token_end_reg,
        run_last_reg, "token end without run last")
    `LPS_ASSERT_SAME(a_empty_byte_zero, clk, rst_n, out_valid_reg && !byte_valid_reg,
        (out_byte_reg == '0) && token_end_reg, "empty result not a clean token end")

endmodule

[rtl/leading_pattern_stripper_core.sv]
// An accepted byte's command is written into the command queue, then loaded into the output register.
// Throughput: one input byte per cycle while the command queue is not full;
// the output side emits one result per cycle while out_stall is low, so a flush
// of held bytes, one result per held byte, is absorbed by the command queue between front and back end.
// Reset: match state returns to the start of a token, the queue and output
// register empty, and the registers return to pattern 0, length 1, limit 0.
module leading_pattern_stripper_core #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int QUEUE_DEPTH       = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  token_byte,
    input  logic        token_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        token_end,
    output logic        run_last
);
    import lps_pkg::*;

    lps_cfg_t cfg_reg;
    lps_cmd_t push_cmd;
    lps_cmd_t head_cmd;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern <= '0;
            cfg_reg.length  <= LEN_W'(1);
            cfg_reg.limit   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STRIP_PATTERN:  cfg_reg.pattern <= cfg_data;
                REG_PATTERN_LENGTH: cfg_reg.length  <= cfg_data[LEN_W-1:0];
                REG_STRIP_LIMIT:    cfg_reg.limit   <= cfg_data[LIM_W-1:0];
                default:            ;
            endcase
        end
    end

    lps_front #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .token_byte(token_byte),
        .token_last(token_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    lps_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .head_cmd(head_cmd),
        .empty   (q_empty)
    );

    lps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .head_cmd  (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .byte_valid(byte_valid),
        .token_end (token_end),
        .run_last  (run_last)
    );

endmodule
